// ===== design/tajp_pkg.sv =====
// ----------------------------------------------------------------------------
// tajp_pkg: shared types and constants
// Types, constants and register indexes shared by the two-axis joint PID.
// ----------------------------------------------------------------------------
`default_nettype none

package tajp_pkg;

  // Width of the joint angle; the setpoint and the angle error wrap at 2^ANGLE_BITS.
  localparam int ANGLE_BITS = 10;

  // Stick deadband and the step reciprocal: step = 1 + |stick|/100,
  // with |stick|/100 computed as (|stick| * 5243) >> 19 (exact up to 1024).
  localparam int unsigned DEADBAND    = 24;
  localparam int unsigned STEP_RECIP  = 5243;
  localparam int unsigned STEP_SHIFT  = 19;
  localparam int unsigned ERROR_WRAP  = 1000;
  localparam int unsigned LIMIT_RESET = 25;

  // Configuration register indexes (word addresses).
  localparam logic [2:0] REG_ROLL_GAIN    = 3'd0;
  localparam logic [2:0] REG_ROLL_ITIME   = 3'd1;
  localparam logic [2:0] REG_ROLL_DTIME   = 3'd2;
  localparam logic [2:0] REG_PITCH_GAIN   = 3'd3;
  localparam logic [2:0] REG_PITCH_ITIME  = 3'd4;
  localparam logic [2:0] REG_PITCH_DTIME  = 3'd5;
  localparam logic [2:0] REG_SAMPLE       = 3'd6;
  localparam logic [2:0] REG_LIMIT        = 3'd7;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ti;
    logic [15:0] td;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [10:0] stick;
    logic [9:0]         angle;
    logic [7:0]         current;
  } lane_in_t;

endpackage

`default_nettype wire

// ===== design/tajp_if.sv =====
// ----------------------------------------------------------------------------
// tajp_if: handshake channels
// Valid/ready channels for the control tick and for its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tajp_tick_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] roll_stick;
  logic signed [10:0] pitch_stick;
  logic [9:0]         roll_angle;
  logic [9:0]         pitch_angle;
  logic [7:0]         roll_current;
  logic [7:0]         pitch_current;

  modport source (output valid, roll_stick, pitch_stick, roll_angle, pitch_angle,
                  roll_current, pitch_current, input ready);
  modport sink (input valid, roll_stick, pitch_stick, roll_angle, pitch_angle,
                roll_current, pitch_current, output ready);
endinterface

interface tajp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] roll_drive;
  logic signed [31:0] pitch_drive;
  logic [9:0]         roll_target;
  logic [9:0]         pitch_target;

  modport source (output valid, roll_drive, pitch_drive, roll_target, pitch_target,
                  input ready);
  modport sink (input valid, roll_drive, pitch_drive, roll_target, pitch_target,
                output ready);
endinterface

`default_nettype wire

// ===== design/two_axis_joint_pid_with_setpoint_top.sv =====
// ----------------------------------------------------------------------------
// two_axis_joint_pid_with_setpoint_top: two-axis joint PID with setpoints
// Register file, roll and pitch lanes, and the output register that merges them.
// ----------------------------------------------------------------------------
// Sequence after an accepted tick beat: setpoint and error, the divider for Kp/Ti,
// the multiplies, the divider for the derivative product over Ts, the summing
// states and then the merge stage, which loads the output register.
// A new tick is not taken while one is in progress; tick.ready returns once the
// result is in the output register, even while that result beat still waits.
// Reset (synchronous, active high) clears the lanes and arms the first-tick snap.
`default_nettype none

module two_axis_joint_pid_with_setpoint_top (
  input  wire logic        clk,
  input  wire logic        rst,
  tajp_tick_if.sink        tick,
  tajp_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers (APB): the user writes only while idle; not enforced.
  tajp_pkg::axis_cfg_t roll_cfg;
  tajp_pkg::axis_cfg_t pitch_cfg;
  logic [15:0]         sample_period;
  logic [7:0]          current_limit;

  logic                cfg_wr;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_cfg      <= '{kp: 16'd0, ti: 16'd1, td: 16'd1};
      pitch_cfg     <= '{kp: 16'd0, ti: 16'd1, td: 16'd1};
      sample_period <= 16'd1;
      current_limit <= 8'(tajp_pkg::LIMIT_RESET);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tajp_pkg::REG_ROLL_GAIN:   roll_cfg.kp   <= pwdata[15:0];
        tajp_pkg::REG_ROLL_ITIME:  roll_cfg.ti   <= pwdata[15:0];
        tajp_pkg::REG_ROLL_DTIME:  roll_cfg.td   <= pwdata[15:0];
        tajp_pkg::REG_PITCH_GAIN:  pitch_cfg.kp  <= pwdata[15:0];
        tajp_pkg::REG_PITCH_ITIME: pitch_cfg.ti  <= pwdata[15:0];
        tajp_pkg::REG_PITCH_DTIME: pitch_cfg.td  <= pwdata[15:0];
        tajp_pkg::REG_SAMPLE:      sample_period <= pwdata[15:0];
        tajp_pkg::REG_LIMIT:       current_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tajp_pkg::REG_ROLL_GAIN:   prdata = 32'(roll_cfg.kp);
      tajp_pkg::REG_ROLL_ITIME:  prdata = 32'(roll_cfg.ti);
      tajp_pkg::REG_ROLL_DTIME:  prdata = 32'(roll_cfg.td);
      tajp_pkg::REG_PITCH_GAIN:  prdata = 32'(pitch_cfg.kp);
      tajp_pkg::REG_PITCH_ITIME: prdata = 32'(pitch_cfg.ti);
      tajp_pkg::REG_PITCH_DTIME: prdata = 32'(pitch_cfg.td);
      tajp_pkg::REG_SAMPLE:      prdata = 32'(sample_period);
      tajp_pkg::REG_LIMIT:       prdata = 32'(current_limit);
      default:                   prdata = '0;
    endcase
  end

  // Tick control. busy covers the time from an accepted tick beat until its
  // result has moved into the output register; the lanes run in lockstep.
  logic busy;
  logic have;
  logic first_tick;
  logic start;
  logic load;

  tajp_pkg::lane_in_t roll_in;
  tajp_pkg::lane_in_t pitch_in;

  logic               roll_done;
  logic               pitch_done;
  logic signed [31:0] roll_drive;
  logic signed [31:0] pitch_drive;
  logic [9:0]         roll_target;
  logic [9:0]         pitch_target;

  assign tick.ready = !busy;
  assign start      = tick.valid && !busy;
  assign load       = have && (!result.valid || result.ready);

  assign roll_in  = '{stick: tick.roll_stick, angle: tick.roll_angle,
                      current: tick.roll_current};
  assign pitch_in = '{stick: tick.pitch_stick, angle: tick.pitch_angle,
                      current: tick.pitch_current};

  tajp_lane u_roll (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .first  (first_tick),
    .inp    (roll_in),
    .cfg    (roll_cfg),
    .ts     (sample_period),
    .limit  (current_limit),
    .done   (roll_done),
    .drive  (roll_drive),
    .target (roll_target)
  );

  tajp_lane u_pitch (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .first  (first_tick),
    .inp    (pitch_in),
    .cfg    (pitch_cfg),
    .ts     (sample_period),
    .limit  (current_limit),
    .done   (pitch_done),
    .drive  (pitch_drive),
    .target (pitch_target)
  );

  // Merge stage: both lanes finish on the same cycle; their results are held
  // in the lanes until the output register is free, then copied in as one beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      have         <= 1'b0;
      first_tick   <= 1'b1;
      result.valid <= 1'b0;
    end else begin
      if (start) begin
        busy       <= 1'b1;
        first_tick <= 1'b0;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        have <= 1'b0;
      end else if (roll_done && pitch_done) begin
        have <= 1'b1;
      end
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.roll_drive   <= roll_drive;
      result.pitch_drive  <= pitch_drive;
      result.roll_target  <= roll_target;
      result.pitch_target <= pitch_target;
    end
  end

endmodule

`default_nettype wire

// ===== design/tajp_lane.sv =====
// ----------------------------------------------------------------------------
// tajp_lane: one axis of the joint controller
// Setpoint tracking and a sequenced PID with one shared multi-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tajp_lane (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               first,
  input  wire tajp_pkg::lane_in_t inp,
  input  wire tajp_pkg::axis_cfg_t cfg,
  input  wire logic [15:0]        ts,
  input  wire logic [7:0]         limit,
  output logic                    done,
  output logic signed [31:0]      drive,
  output logic [9:0]              target
);

  localparam int AB = tajp_pkg::ANGLE_BITS;
  localparam int EW = (AB + 2 > 12) ? AB + 2 : 12;
  localparam int DW = EW + 31;
  localparam int SW = EW + 34;
  localparam int IW = EW + 17;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [EW-1:0] RANGE  = EW'(1) << AB;
  localparam logic signed [EW-1:0] WRAP_P = EW'(tajp_pkg::ERROR_WRAP);
  localparam logic signed [EW-1:0] WRAP_N = -EW'(tajp_pkg::ERROR_WRAP);
  localparam logic signed [SW-1:0] MAXV   = (SW'(1) << 31) - SW'(1);
  localparam logic signed [SW-1:0] MINV   = -(SW'(1) << 31);
  localparam logic signed [10:0]   DB_P   = 11'(tajp_pkg::DEADBAND);
  localparam logic signed [10:0]   DB_N   = -11'(tajp_pkg::DEADBAND);

  typedef enum logic [3:0] {
    S_IDLE, S_SETP, S_ERR, S_PROD, S_DIVQ, S_MUL2, S_MUL3, S_DIVD, S_SUM1, S_SUM2
  } state_t;

  state_t state;

  logic signed [10:0]   stick;
  logic [AB-1:0]        angle;
  logic [7:0]           cur;
  logic                 first_r;
  logic [AB-1:0]        setpoint;
  logic                 holding;
  logic signed [EW-1:0] prev_e;
  logic signed [31:0]   integ;
  logic signed [EW-1:0] e_r;
  logic signed [EW-1:0] avg_r;
  logic signed [EW-1:0] diff_r;
  logic signed [SW-1:0] kpe;
  logic [31:0]          kptd;
  logic signed [IW-1:0] inc_a;
  logic signed [DW:0]   der_p;
  logic signed [SW-1:0] inc;
  logic signed [SW-1:0] der;
  logic signed [SW-1:0] s1;
  logic                 der_neg;
  logic [DW-1:0]        quo;
  logic [15:0]          rem;
  logic [15:0]          den;
  logic [CW-1:0]        cnt;

  // Setpoint step from the stick magnitude.
  logic [10:0]          mag;
  logic [23:0]          recip;
  logic [4:0]           step;
  logic [AB+9:0]        angle_wide;
  logic [AB+9:0]        sp_wide;
  logic signed [EW-1:0] e_raw;
  logic signed [EW-1:0] e_wrap;
  logic signed [EW:0]   sum_e;
  logic signed [EW:0]   sum_adj;
  logic [16:0]          rem_sh;
  logic                 ge;
  logic [15:0]          rem_nx;
  logic [DW-1:0]        quo_nx;
  logic [DW-1:0]        der_mag;
  logic signed [SW-1:0] total;
  logic signed [SW-1:0] integ_sum;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > MAXV) begin
      return 32'sh7fffffff;
    end else if (v < MINV) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    mag        = stick[10] ? 11'(-stick) : 11'(stick);
    recip      = 24'(mag) * 24'(tajp_pkg::STEP_RECIP);
    step       = 5'd1 + recip[23:tajp_pkg::STEP_SHIFT];
    angle_wide = (AB + 10)'(inp.angle);
    sp_wide    = (AB + 10)'(setpoint);
    e_raw      = EW'(setpoint) - EW'(angle);
    e_wrap     = e_raw;
    if (e_raw > WRAP_P) begin
      e_wrap = e_raw - RANGE;
    end else if (e_raw < WRAP_N) begin
      e_wrap = e_raw + RANGE;
    end
    // Average of this and the previous error, truncated toward zero.
    sum_e     = (EW + 1)'(e_r) + (EW + 1)'(prev_e);
    sum_adj   = sum_e + (EW + 1)'(sum_e[EW]);
    // One restoring-division step.
    rem_sh    = {rem, quo[DW-1]};
    ge        = rem_sh >= {1'b0, den};
    rem_nx    = ge ? 16'(rem_sh - {1'b0, den}) : rem_sh[15:0];
    quo_nx    = {quo[DW-2:0], ge};
    der_mag   = der_p[DW] ? DW'(-der_p) : DW'(der_p);
    total     = s1 + der;
    integ_sum = SW'(integ) + inc;
  end

  assign target = sp_wide[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      setpoint <= '0;
      holding  <= 1'b0;
      prev_e   <= '0;
      integ    <= '0;
      drive    <= '0;
    end else begin
      done <= (state == S_SUM2);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            stick   <= inp.stick;
            angle   <= angle_wide[AB-1:0];
            cur     <= inp.current;
            first_r <= first;
            state   <= S_SETP;
          end
        end
        S_SETP: begin
          if (first_r) begin
            setpoint <= angle;
          end else if (stick > DB_P) begin
            setpoint <= setpoint + AB'(step);
          end else if (stick < DB_N) begin
            setpoint <= setpoint - AB'(step);
          end else if (stick != DB_P && stick != DB_N && !holding) begin
            setpoint <= angle;
          end
          if (stick > DB_P || stick < DB_N) begin
            holding <= 1'b0;
          end else if (stick != DB_P && stick != DB_N && !holding) begin
            holding <= 1'b1;
          end
          state <= S_ERR;
        end
        S_ERR: begin
          e_r   <= e_wrap;
          state <= S_PROD;
        end
        S_PROD: begin
          kpe    <= SW'(cfg.kp) * SW'(e_r);
          kptd   <= 32'(cfg.kp) * 32'(cfg.td);
          avg_r  <= sum_adj[EW:1];
          diff_r <= e_r - prev_e;
          quo    <= {cfg.kp, (DW - 16)'(0)};
          rem    <= '0;
          den    <= (cfg.ti == 16'd0) ? 16'd1 : cfg.ti;
          cnt    <= CW'(16);
          state  <= S_DIVQ;
        end
        S_DIVQ: begin
          quo <= quo_nx;
          rem <= rem_nx;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          inc_a <= IW'(quo[15:0]) * IW'(avg_r);
          der_p <= (DW + 1)'(kptd) * (DW + 1)'(diff_r);
          state <= S_MUL3;
        end
        S_MUL3: begin
          inc     <= SW'(inc_a) * SW'(ts);
          der_neg <= der_p[DW];
          quo     <= der_mag;
          rem     <= '0;
          den     <= (ts == 16'd0) ? 16'd1 : ts;
          cnt     <= CW'(DW);
          state   <= S_DIVD;
        end
        S_DIVD: begin
          quo <= quo_nx;
          rem <= rem_nx;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_SUM1;
          end
        end
        S_SUM1: begin
          der   <= der_neg ? -SW'(quo) : SW'(quo);
          s1    <= kpe + SW'(integ) + inc;
          state <= S_SUM2;
        end
        S_SUM2: begin
          drive  <= (cur < limit) ? sat32(total) : 32'sd0;
          integ  <= sat32(integ_sum);
          prev_e <= e_r;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
